// File: rtl/tlcd_pkg.sv
// ----------------------------------------------------------------------------
// tlcd_pkg: shared types and constants for the text lcd byte formatter
// request codes, queued operation and output word formats, font and gauge tables
// ----------------------------------------------------------------------------
`default_nettype none

package tlcd_pkg;

	// request codes on the cmd port
	localparam logic [2:0] CMD_CHAR     = 3'd0;
	localparam logic [2:0] CMD_POS      = 3'd1;
	localparam logic [2:0] CMD_GAUGE    = 3'd2;
	localparam logic [2:0] CMD_RAW_CMD  = 3'd3;
	localparam logic [2:0] CMD_RAW_DATA = 3'd4;

	// character range covered by the font
	localparam logic [7:0] FIRST_CHAR = 8'd32;
	localparam logic [7:0] LAST_CHAR  = 8'd122;

	// position command bytes
	localparam logic [7:0] COL_FLAG = 8'h80;
	localparam logic [7:0] ROW_FLAG = 8'h40;
	localparam int         ROW_W    = 3;

	// battery gauge
	localparam logic [7:0] GAUGE_COL  = 8'd71;
	localparam logic [7:0] GAUGE_FULL = 8'd12;
	localparam logic [7:0] GAUGE_FILL = 8'hFE;
	localparam logic [7:0] GAUGE_CAP  = 8'h38;
	localparam logic [7:0] GAUGE_EDGE = 8'hFE;
	localparam logic [7:0] GAUGE_SIDE = 8'h82;
	localparam int         GAUGE_LEN  = 13;

	// byte sequencer steps
	localparam int             STEP_W           = 4;
	localparam logic [STEP_W-1:0] GLYPH_COLS    = STEP_W'(5);
	localparam logic [STEP_W-1:0] CHAR_LAST     = STEP_W'(5);
	localparam logic [STEP_W-1:0] POS_LAST      = STEP_W'(1);
	localparam logic [STEP_W-1:0] GAUGE_FIRST   = STEP_W'(2);
	localparam logic [STEP_W-1:0] GAUGE_LAST    = STEP_W'(2 + GAUGE_LEN - 1);

	// classified operation kinds
	typedef enum logic [2:0] {
		OP_CHAR,
		OP_POS,
		OP_GAUGE,
		OP_RAW_CMD,
		OP_RAW_DATA
	} op_kind_t;

	// queued operation: arg is glyph index, column, gauge threshold or raw byte
	typedef struct packed {
		op_kind_t         kind;
		logic [7:0]       arg;
		logic [ROW_W-1:0] row;
	} op_t;

	// one output word
	typedef struct packed {
		logic       is_data;
		logic [7:0] data;
		logic       last;
	} out_word_t;

	// gauge outline column
	function automatic logic [7:0] gauge_outline(input logic [STEP_W-1:0] col);
		logic [7:0] b;
		begin
			if (col == STEP_W'(0))
				b = GAUGE_CAP;
			else if (col == STEP_W'(1) || col == STEP_W'(GAUGE_LEN - 1))
				b = GAUGE_EDGE;
			else
				b = GAUGE_SIDE;
			return b;
		end
	endfunction

	// 5x7 font, column 0 in bits 39:32
	function automatic logic [39:0] font_row(input logic [6:0] idx);
		logic [39:0] r;
		begin
			unique case (idx)
				7'd0:  r = 40'h0000000000;
				7'd1:  r = 40'h00002f0000;
				7'd2:  r = 40'h0007000700;
				7'd3:  r = 40'h147f147f14;
				7'd4:  r = 40'h242a7f2a12;
				7'd5:  r = 40'h2313086462;
				7'd6:  r = 40'h3649552250;
				7'd7:  r = 40'h0005030000;
				7'd8:  r = 40'h001c224100;
				7'd9:  r = 40'h0041221c00;
				7'd10: r = 40'h14083e0814;
				7'd11: r = 40'h08083e0808;
				7'd12: r = 40'h0000503000;
				7'd13: r = 40'h1010101010;
				7'd14: r = 40'h0060600000;
				7'd15: r = 40'h2010080402;
				7'd16: r = 40'h3e5149453e;
				7'd17: r = 40'h00427f4000;
				7'd18: r = 40'h4261514946;
				7'd19: r = 40'h2141454b31;
				7'd20: r = 40'h1814127f10;
				7'd21: r = 40'h2745454539;
				7'd22: r = 40'h3c4a494930;
				7'd23: r = 40'h0171090503;
				7'd24: r = 40'h3649494936;
				7'd25: r = 40'h064949291e;
				7'd26: r = 40'h0036360000;
				7'd27: r = 40'h0056360000;
				7'd28: r = 40'h0814224100;
				7'd29: r = 40'h1414141414;
				7'd30: r = 40'h0041221408;
				7'd31: r = 40'h0201510906;
				7'd32: r = 40'h324959513e;
				7'd33: r = 40'h7e1111117e;
				7'd34: r = 40'h7f49494936;
				7'd35: r = 40'h3e41414122;
				7'd36: r = 40'h7f4141221c;
				7'd37: r = 40'h7f49494941;
				7'd38: r = 40'h7f09090901;
				7'd39: r = 40'h3e4149497a;
				7'd40: r = 40'h7f0808087f;
				7'd41: r = 40'h00417f4100;
				7'd42: r = 40'h2040413f01;
				7'd43: r = 40'h7f08142241;
				7'd44: r = 40'h7f40404040;
				7'd45: r = 40'h7f020c027f;
				7'd46: r = 40'h7f0408107f;
				7'd47: r = 40'h3e4141413e;
				7'd48: r = 40'h7f09090906;
				7'd49: r = 40'h3e4151215e;
				7'd50: r = 40'h7f09192946;
				7'd51: r = 40'h4649494931;
				7'd52: r = 40'h01017f0101;
				7'd53: r = 40'h3f4040403f;
				7'd54: r = 40'h1f2040201f;
				7'd55: r = 40'h3f4038403f;
				7'd56: r = 40'h6314081463;
				7'd57: r = 40'h0708700807;
				7'd58: r = 40'h6151494543;
				7'd59: r = 40'h007f414100;
				7'd60: r = 40'h552a552a55;
				7'd61: r = 40'h0041417f00;
				7'd62: r = 40'h0402010204;
				7'd63: r = 40'h4040404040;
				7'd64: r = 40'h0001020400;
				7'd65: r = 40'h2054545478;
				7'd66: r = 40'h7f48444438;
				7'd67: r = 40'h3844444420;
				7'd68: r = 40'h384444487f;
				7'd69: r = 40'h3854545418;
				7'd70: r = 40'h087e090102;
				7'd71: r = 40'h0c5252523e;
				7'd72: r = 40'h7f08040478;
				7'd73: r = 40'h00447d4000;
				7'd74: r = 40'h2040443d00;
				7'd75: r = 40'h7f10284400;
				7'd76: r = 40'h00417f4000;
				7'd77: r = 40'h7c04180478;
				7'd78: r = 40'h7c08040478;
				7'd79: r = 40'h3844444438;
				7'd80: r = 40'h7c14141408;
				7'd81: r = 40'h081414187c;
				7'd82: r = 40'h7c08040408;
				7'd83: r = 40'h4854545420;
				7'd84: r = 40'h043f444020;
				7'd85: r = 40'h3c4040207c;
				7'd86: r = 40'h1c2040201c;
				7'd87: r = 40'h3c4030403c;
				7'd88: r = 40'h4428102844;
				7'd89: r = 40'h0c5050503c;
				7'd90: r = 40'h4464544c44;
				default: r = 40'h0000000000;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/tlcd_fifo.sv
// ----------------------------------------------------------------------------
// tlcd_fifo: small first-in first-out queue
// register array with read and write pointers and an occupancy count
// ----------------------------------------------------------------------------
`default_nettype none

module tlcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// status
	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == CNT_W'(0));
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/tlcd_front.sv
// ----------------------------------------------------------------------------
// tlcd_front: request classifier
// decodes a request into a queued operation and drops requests that give nothing
// ----------------------------------------------------------------------------
`default_nettype none

module tlcd_front (
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] value,
	input  wire logic [7:0] row,
	output tlcd_pkg::op_t   op,
	output logic            keep
);

	// decode request
	always_comb begin
		op.kind = tlcd_pkg::OP_RAW_CMD;
		op.arg  = value;
		op.row  = row[tlcd_pkg::ROW_W-1:0];
		keep    = 1'b0;
		unique case (cmd)
			tlcd_pkg::CMD_CHAR: begin
				op.kind = tlcd_pkg::OP_CHAR;
				op.arg  = value - tlcd_pkg::FIRST_CHAR;
				keep    = (value >= tlcd_pkg::FIRST_CHAR) && (value <= tlcd_pkg::LAST_CHAR);
			end
			tlcd_pkg::CMD_POS: begin
				op.kind = tlcd_pkg::OP_POS;
				keep    = 1'b1;
			end
			tlcd_pkg::CMD_GAUGE: begin
				// threshold column, wraps for levels above full
				op.kind = tlcd_pkg::OP_GAUGE;
				op.arg  = tlcd_pkg::GAUGE_FULL - value;
				keep    = 1'b1;
			end
			tlcd_pkg::CMD_RAW_CMD: begin
				op.kind = tlcd_pkg::OP_RAW_CMD;
				keep    = 1'b1;
			end
			tlcd_pkg::CMD_RAW_DATA: begin
				op.kind = tlcd_pkg::OP_RAW_DATA;
				keep    = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/tlcd_back.sv
// ----------------------------------------------------------------------------
// tlcd_back: byte sequencer
// walks the operation at the queue head and, while the output queue has room, emits one word per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tlcd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tlcd_pkg::op_t   head,
	input  wire logic            head_valid,
	input  wire logic            out_full,
	output logic                 head_pop,
	output logic                 word_wr,
	output tlcd_pkg::out_word_t  word
);

	logic [tlcd_pkg::STEP_W-1:0] step_q;
	logic [tlcd_pkg::STEP_W-1:0] gauge_idx;
	logic [39:0]                 glyph;
	logic [7:0]                  glyph_byte;
	logic [7:0]                  gauge_byte;

	assign word_wr  = head_valid & ~out_full;
	assign head_pop = word_wr & word.last;

	// glyph column select
	always_comb begin
		glyph = tlcd_pkg::font_row(head.arg[6:0]);
		unique case (step_q)
			tlcd_pkg::STEP_W'(0): glyph_byte = glyph[39:32];
			tlcd_pkg::STEP_W'(1): glyph_byte = glyph[31:24];
			tlcd_pkg::STEP_W'(2): glyph_byte = glyph[23:16];
			tlcd_pkg::STEP_W'(3): glyph_byte = glyph[15:8];
			tlcd_pkg::STEP_W'(4): glyph_byte = glyph[7:0];
			default:              glyph_byte = 8'h00;
		endcase
	end

	// gauge column: filled from the threshold onward
	assign gauge_idx  = step_q - tlcd_pkg::GAUGE_FIRST;
	assign gauge_byte = ({4'b0000, gauge_idx} >= head.arg) ? tlcd_pkg::GAUGE_FILL
		: tlcd_pkg::gauge_outline(gauge_idx);

	// word formatting
	always_comb begin
		word.is_data = 1'b1;
		word.data    = head.arg;
		word.last    = 1'b1;
		unique case (head.kind)
			tlcd_pkg::OP_CHAR: begin
				word.is_data = 1'b1;
				word.data    = (step_q < tlcd_pkg::GLYPH_COLS) ? glyph_byte : 8'h00;
				word.last    = (step_q == tlcd_pkg::CHAR_LAST);
			end
			tlcd_pkg::OP_POS: begin
				word.is_data = 1'b0;
				word.data    = (step_q == tlcd_pkg::STEP_W'(0))
					? (head.arg | tlcd_pkg::COL_FLAG)
					: ({5'b00000, head.row} | tlcd_pkg::ROW_FLAG);
				word.last    = (step_q == tlcd_pkg::POS_LAST);
			end
			tlcd_pkg::OP_GAUGE: begin
				word.last = (step_q == tlcd_pkg::GAUGE_LAST);
				if (step_q == tlcd_pkg::STEP_W'(0)) begin
					word.is_data = 1'b0;
					word.data    = tlcd_pkg::GAUGE_COL | tlcd_pkg::COL_FLAG;
				end else if (step_q == tlcd_pkg::STEP_W'(1)) begin
					word.is_data = 1'b0;
					word.data    = tlcd_pkg::ROW_FLAG;
				end else begin
					word.is_data = 1'b1;
					word.data    = gauge_byte;
				end
			end
			tlcd_pkg::OP_RAW_CMD: begin
				word.is_data = 1'b0;
			end
			tlcd_pkg::OP_RAW_DATA: begin
				word.is_data = 1'b1;
			end
			default: begin
				word.is_data = 1'b1;
			end
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (word_wr) begin
			step_q <= word.last ? '0 : step_q + tlcd_pkg::STEP_W'(1);
		end
	end

endmodule

`default_nettype wire

// File: rtl/text_lcd_byte_formatter.sv
// ----------------------------------------------------------------------------
// text_lcd_byte_formatter: request to display byte stream formatter
// character, position, battery gauge and raw requests become tagged bytes
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: present cmd/value/row and raise push; the word is
//   taken at an edge where full is low. requests that give no bytes (unknown
//   cmd, character outside 32..122) are dropped at the input.
//   output side is a queue: while empty is low, is_data/out_byte/last show
//   the oldest byte; raise pop to take it. last marks the final byte of a
//   request.
//   path: a taken request is registered in the request queue; the sequencer
//   then writes its first byte into the output queue when it is free.
//   throughput: the sequencer emits one byte per cycle while the output
//   queue has room; requests give 1 raw, 2 position, 6 char, 15 gauge bytes.
//   up to QUEUE_DEPTH requests wait between the classifier and the sequencer.
//   stall: when pop stays low the two-word output queue fills, the sequencer
//   holds, the request queue fills and full rises; nothing is lost.
//   reset: both queues empty and the sequencer returns to its first step.
// ----------------------------------------------------------------------------
`default_nettype none

module text_lcd_byte_formatter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] value,
	input  wire logic [7:0] row,
	output logic            empty,
	input  wire logic       pop,
	output logic            is_data,
	output logic [7:0]      out_byte,
	output logic            last
);

	localparam int OUT_DEPTH = 2;
	localparam int OP_W      = $bits(tlcd_pkg::op_t);
	localparam int WORD_W    = $bits(tlcd_pkg::out_word_t);

	tlcd_pkg::op_t       new_op;
	logic                new_keep;
	logic [OP_W-1:0]     head_bits;
	tlcd_pkg::op_t       head;
	logic                op_empty;
	logic                head_pop;
	logic                word_wr;
	tlcd_pkg::out_word_t word;
	logic                out_full;
	logic [WORD_W-1:0]   out_bits;
	tlcd_pkg::out_word_t out_word;

	// classifier
	tlcd_front u_front (
		.cmd   (cmd),
		.value (value),
		.row   (row),
		.op    (new_op),
		.keep  (new_keep)
	);

	// request queue
	tlcd_fifo #(
		.WIDTH (OP_W),
		.DEPTH (QUEUE_DEPTH)
	) u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push & new_keep),
		.wr_data (new_op),
		.rd_en   (head_pop),
		.rd_data (head_bits),
		.full    (full),
		.empty   (op_empty)
	);

	assign head = tlcd_pkg::op_t'(head_bits);

	// sequencer
	tlcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (~op_empty),
		.out_full   (out_full),
		.head_pop   (head_pop),
		.word_wr    (word_wr),
		.word       (word)
	);

	// output queue
	tlcd_fifo #(
		.WIDTH (WORD_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (word_wr),
		.wr_data (word),
		.rd_en   (pop),
		.rd_data (out_bits),
		.full    (out_full),
		.empty   (empty)
	);

	assign out_word = tlcd_pkg::out_word_t'(out_bits);
	assign is_data  = out_word.is_data;
	assign out_byte = out_word.data;
	assign last     = out_word.last;

endmodule

`default_nettype wire
